@@ hw/rtl/qau_pkg.sv @@
// Quaternion arithmetic unit: shared constants, command and status codes.
// No dependencies; every other file of the unit refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int FRACTION_BITS   = 14;
	localparam int CMD_WIDTH       = 3;
	localparam int STATUS_WIDTH    = 2;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_MUL   = 3'd0,
		CMD_DELTA = 3'd1,
		CMD_ROT   = 3'd2,
		CMD_IROT  = 3'd3,
		CMD_NORM  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ hw/rtl/qau_if.sv @@
// Request and response channels of the quaternion unit (valid/ready).
// Depends on qau_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface qau_req_if #(parameter int W = qau_pkg::COMPONENT_WIDTH);
	logic                              valid;
	logic                              ready;
	logic [qau_pkg::CMD_WIDTH-1:0]     cmd;
	logic signed [W-1:0]               a_w;
	logic signed [W-1:0]               a_x;
	logic signed [W-1:0]               a_y;
	logic signed [W-1:0]               a_z;
	logic signed [W-1:0]               b_w;
	logic signed [W-1:0]               b_x;
	logic signed [W-1:0]               b_y;
	logic signed [W-1:0]               b_z;

	modport source (output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
	modport sink (input valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface qau_rsp_if #(parameter int W = qau_pkg::COMPONENT_WIDTH);
	logic                              valid;
	logic                              ready;
	logic signed [W-1:0]               r_w;
	logic signed [W-1:0]               r_x;
	logic signed [W-1:0]               r_y;
	logic signed [W-1:0]               r_z;
	logic [qau_pkg::STATUS_WIDTH-1:0]  status;

	modport source (output valid, r_w, r_x, r_y, r_z, status, input ready);
	modport sink (input valid, r_w, r_x, r_y, r_z, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/qau_isqrt.sv @@
// Pipelined integer square root, one root bit per stage (W+1 stages).
// Depends on qau_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

module qau_isqrt #(
	parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [2*COMPONENT_WIDTH:0]   s,
	output      logic [COMPONENT_WIDTH:0]     m
);

	localparam int W  = COMPONENT_WIDTH;
	localparam int NS = W + 1;
	localparam int TW = 2 * W + 3;

	logic [TW-1:0] rem_s  [NS];
	logic [W:0]    root_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		localparam int K = NS - 1 - g;
		logic [TW-1:0] rem_in;
		logic [W:0]    root_in;
		logic [TW-1:0] trial;

		if (g == 0) begin : g_first
			assign rem_in  = TW'(s);
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
		end

		// (r + 2^k)^2 - r^2
		assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[g]  <= rem_in - trial;
					root_s[g] <= root_in | ((W+1)'(1) << K);
				end else begin
					rem_s[g]  <= rem_in;
					root_s[g] <= root_in;
				end
			end
		end
	end

	assign m = root_s[NS-1];

endmodule

`default_nettype wire

@@ hw/rtl/qau_div.sv @@
// Pipelined restoring divider, one quotient bit per stage (F+1 stages).
// Depends on qau_pkg for default widths; quotient must stay below 2^(F+1).
`timescale 1ns / 1ps
`default_nettype none

module qau_div #(
	parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS
) (
	input  wire logic                                        clk,
	input  wire logic                                        en,
	input  wire logic [COMPONENT_WIDTH+FRACTION_BITS+1:0]    num,
	input  wire logic [COMPONENT_WIDTH+1:0]                  den,
	output      logic [FRACTION_BITS:0]                      q
);

	localparam int NW   = COMPONENT_WIDTH + FRACTION_BITS + 2;
	localparam int DENW = COMPONENT_WIDTH + 2;
	localparam int QB   = FRACTION_BITS + 1;

	logic [NW-1:0]   rem_s [QB];
	logic [DENW-1:0] den_s [QB];
	logic [QB-1:0]   q_s   [QB];

	for (genvar g = 0; g < QB; g++) begin : g_stage
		localparam int K = QB - 1 - g;
		logic [NW-1:0]   rem_in;
		logic [DENW-1:0] den_in;
		logic [QB-1:0]   q_in;
		logic [NW-1:0]   sh;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign den_in = den_s[g-1];
			assign q_in   = q_s[g-1];
		end

		assign sh = NW'(den_in) << K;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g] <= den_in;
				if (rem_in >= sh) begin
					rem_s[g] <= rem_in - sh;
					q_s[g]   <= q_in | (QB'(1) << K);
				end else begin
					rem_s[g] <= rem_in;
					q_s[g]   <= q_in;
				end
			end
		end
	end

	assign q = q_s[QB-1];

endmodule

`default_nettype wire

@@ hw/rtl/quaternion_arithmetic_unit_top.sv @@
// Quaternion arithmetic unit top: product, delta, rotations and normalize.
// Depends on qau_pkg, qau_if, qau_isqrt and qau_div.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | cmd, a_w..a_z, b_w..b_z                   | valid/ready
//  rsp     | out | r_w, r_x, r_y, r_z, status                | valid/ready
//
// One request per cycle while the skid register is empty. The pipe holds
// the root pipeline (W+1 stages) and the four divider lanes (F+1 stages).
// All commands travel the same pipe, so results leave in request order.
// Reset clears the valid bits only. The pipe advances as one unit while the
// output skid register is empty; a stalled response fills the skid and holds.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit_top #(
	parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	qau_req_if.sink   req,
	qau_rsp_if.source rsp
);

	localparam int W    = COMPONENT_WIDTH;
	localparam int F    = FRACTION_BITS;
	localparam int NS   = W + 1;
	localparam int QB   = F + 1;
	localparam int SSTG = NS + 3;          // divider setup stage
	localparam int L    = SSTG + QB + 1;   // final select stage
	localparam int SW   = 2 * W + 1;
	localparam int PW   = 2 * W;
	localparam int SUMW = 2 * W + 2;
	localparam int CPW  = 3 * W + 2;
	localparam int NW   = W + F + 2;
	localparam int DENW = W + 2;
	localparam int ACCW = (3 * W + 4 > 2 * F + 1) ? 3 * W + 4 : 2 * F + 1;

	localparam logic signed [ACCW-1:0] HALF_Q = ACCW'(1) << (F - 1);
	localparam logic signed [ACCW-1:0] HALF_R = ACCW'(1) << (2 * F - 2);
	localparam logic signed [ACCW-1:0] SAT_HI = (ACCW'(1) << (W - 1)) - ACCW'(1);
	localparam logic signed [ACCW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [W-1:0] val;
		logic         ovf;
	} sat_t;

	typedef struct packed {
		logic [3:0][W-1:0] r;
		logic              ovf;
	} arith_t;

	typedef struct packed {
		logic [3:0][W-1:0] mag;
		logic [3:0]        neg;
		logic              zero;
	} nrm_t;

	typedef struct packed {
		logic [3:0][W-1:0]  r;
		qau_pkg::status_t   status;
	} res_t;

	function automatic sat_t sat_fn(input logic signed [ACCW-1:0] v);
		sat_t o;
		if (v > SAT_HI) begin
			o.val = SAT_HI[W-1:0];
			o.ovf = 1'b1;
		end else if (v < SAT_LO) begin
			o.val = SAT_LO[W-1:0];
			o.ovf = 1'b1;
		end else begin
			o.val = v[W-1:0];
			o.ovf = 1'b0;
		end
		return o;
	endfunction

	logic en;
	logic [L:1] v_p;
	qau_pkg::cmd_t cmd_p [1:L-1];
	nrm_t          nrm_p [1:L-1];
	arith_t        ar_p  [4:L-1];

	// ---------------- stage 1: all sixteen products ----------------
	logic signed [W-1:0]  ain [4];
	logic signed [W-1:0]  bin [4];
	logic signed [W-1:0]  bsel [4];
	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [W-1:0]  ax_s1 [3];
	logic signed [W-1:0]  vec_s1 [3];
	nrm_t                 nrm_c;

	assign ain = '{req.a_w, req.a_x, req.a_y, req.a_z};
	assign bin = '{req.b_w, req.b_x, req.b_y, req.b_z};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			// normalize squares a, so the diagonal products are a_i^2
			bsel[i] = (qau_pkg::cmd_t'(req.cmd) == qau_pkg::CMD_NORM) ? ain[i] : bin[i];
			nrm_c.neg[i] = ain[i][W-1];
			nrm_c.mag[i] = ain[i][W-1] ? (~ain[i] + W'(1)) : ain[i];
		end
		nrm_c.zero = (ain[0] == '0) && (ain[1] == '0) && (ain[2] == '0) && (ain[3] == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= ain[i] * bsel[j];
				end
			end
			for (int i = 0; i < 3; i++) begin
				ax_s1[i]  <= ain[i+1];
				vec_s1[i] <= bin[i+1];
			end
		end
	end

	// ---------------- stage 2: sums ----------------
	logic signed [SUMW-1:0] pe [4][4];
	logic signed [SUMW-1:0] quat_c [4];
	logic signed [SUMW-1:0] t_c [3];
	logic signed [SUMW-1:0] cr [3];
	logic [SW-1:0]          s_c;
	logic signed [SUMW-1:0] quat_s2 [4];
	logic signed [SUMW-1:0] t_s2 [3];
	logic [SW-1:0]          s_s2;
	logic signed [W-1:0]    ax_s2 [3];
	logic signed [W-1:0]    vec_s2 [3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pe[i][j] = SUMW'(prod_s1[i][j]);
			end
		end
		if (cmd_p[1] == qau_pkg::CMD_DELTA) begin
			quat_c[0] = pe[0][0] + pe[1][1] + pe[2][2] + pe[3][3];
			quat_c[1] = pe[0][1] - pe[1][0] - pe[2][3] + pe[3][2];
			quat_c[2] = pe[0][2] + pe[1][3] - pe[2][0] - pe[3][1];
			quat_c[3] = pe[0][3] - pe[1][2] + pe[2][1] - pe[3][0];
		end else begin
			quat_c[0] = pe[0][0] - pe[1][1] - pe[2][2] - pe[3][3];
			quat_c[1] = pe[0][1] + pe[1][0] + pe[2][3] - pe[3][2];
			quat_c[2] = pe[0][2] - pe[1][3] + pe[2][0] + pe[3][1];
			quat_c[3] = pe[0][3] + pe[1][2] - pe[2][1] + pe[3][0];
		end
		cr[0] = pe[2][3] - pe[3][2];
		cr[1] = pe[3][1] - pe[1][3];
		cr[2] = pe[1][2] - pe[2][1];
		// inverse rotation uses cross(v, q) = -cross(q, v)
		for (int i = 0; i < 3; i++) begin
			t_c[i] = ((cmd_p[1] == qau_pkg::CMD_IROT) ? -cr[i] : cr[i]) + pe[0][i+1];
		end
		s_c = SW'(unsigned'(prod_s1[0][0])) + SW'(unsigned'(prod_s1[1][1]))
			+ SW'(unsigned'(prod_s1[2][2])) + SW'(unsigned'(prod_s1[3][3]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_s2 <= quat_c;
			t_s2    <= t_c;
			s_s2    <= s_c;
			ax_s2   <= ax_s1;
			vec_s2  <= vec_s1;
		end
	end

	// ---------------- stage 3: quaternion rounding, second cross products ----------------
	sat_t                   qsat [4];
	logic [W-1:0]           qr_s3 [4];
	logic                   qflag_s3;
	logic signed [CPW-1:0]  cp_s3 [6];
	logic signed [W-1:0]    vec_s3 [3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qsat[i] = sat_fn((ACCW'(quat_s2[i]) + HALF_Q) >>> F);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				qr_s3[i] <= qsat[i].val;
			end
			qflag_s3 <= qsat[0].ovf | qsat[1].ovf | qsat[2].ovf | qsat[3].ovf;
			cp_s3[0] <= ax_s2[1] * t_s2[2];
			cp_s3[1] <= ax_s2[2] * t_s2[1];
			cp_s3[2] <= ax_s2[2] * t_s2[0];
			cp_s3[3] <= ax_s2[0] * t_s2[2];
			cp_s3[4] <= ax_s2[0] * t_s2[1];
			cp_s3[5] <= ax_s2[1] * t_s2[0];
			vec_s3   <= vec_s2;
		end
	end

	// ---------------- stage 4: rotation result, arithmetic result ----------------
	arith_t                 ar_c;
	logic signed [ACCW-1:0] cc;
	sat_t                   rsat;

	always_comb begin
		ar_c = '0;
		cc   = '0;
		rsat = '0;
		case (cmd_p[3])
			qau_pkg::CMD_MUL, qau_pkg::CMD_DELTA: begin
				for (int i = 0; i < 4; i++) begin
					ar_c.r[i] = qr_s3[i];
				end
				ar_c.ovf = qflag_s3;
			end
			qau_pkg::CMD_ROT, qau_pkg::CMD_IROT: begin
				for (int i = 0; i < 3; i++) begin
					cc = ACCW'(cp_s3[2*i]) - ACCW'(cp_s3[2*i+1]);
					if (cmd_p[3] == qau_pkg::CMD_IROT) begin
						cc = -cc;
					end
					rsat = sat_fn(((cc + HALF_R) >>> (2 * F - 1)) + ACCW'(vec_s3[i]));
					ar_c.r[i+1] = rsat.val;
					ar_c.ovf    = ar_c.ovf | rsat.ovf;
				end
			end
			default: ar_c = '0;
		endcase
	end

	// ---------------- normalize: root, divider setup, divider lanes ----------------
	logic [W:0]      m_root;
	logic [NW-1:0]   num_ss [4];
	logic [DENW-1:0] den_ss;
	logic [QB-1:0]   q_lane [4];

	qau_isqrt #(.COMPONENT_WIDTH(W)) u_isqrt (
		.clk (clk),
		.en  (en),
		.s   (s_s2),
		.m   (m_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				// round to nearest: (2*|a|*2^F + m) / (2*m)
				num_ss[i] <= (NW'(nrm_p[SSTG-1].mag[i]) << (F + 1)) + NW'(m_root);
			end
			den_ss <= DENW'(m_root) << 1;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		qau_div #(.COMPONENT_WIDTH(W), .FRACTION_BITS(F)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_ss[g]),
			.den (den_ss),
			.q   (q_lane[g])
		);
	end

	// ---------------- delay lines ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_p[1] <= qau_pkg::cmd_t'(req.cmd);
			nrm_p[1] <= nrm_c;
			for (int k = 2; k <= L - 1; k++) begin
				cmd_p[k] <= cmd_p[k-1];
				nrm_p[k] <= nrm_p[k-1];
			end
			ar_p[4] <= ar_c;
			for (int k = 5; k <= L - 1; k++) begin
				ar_p[k] <= ar_p[k-1];
			end
		end
	end

	// ---------------- final stage: select ----------------
	res_t                   res_c;
	res_t                   res_sl;
	logic signed [ACCW-1:0] nv;
	sat_t                   nsat;
	logic                   nflag;

	always_comb begin
		res_c = '0;
		nv    = '0;
		nsat  = '0;
		nflag = 1'b0;
		case (cmd_p[L-1])
			qau_pkg::CMD_MUL, qau_pkg::CMD_DELTA, qau_pkg::CMD_ROT, qau_pkg::CMD_IROT: begin
				res_c.r      = ar_p[L-1].r;
				res_c.status = ar_p[L-1].ovf ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
			end
			qau_pkg::CMD_NORM: begin
				if (nrm_p[L-1].zero) begin
					res_c.status = qau_pkg::ST_ZERO;
				end else begin
					for (int i = 0; i < 4; i++) begin
						nv = signed'(ACCW'(q_lane[i]));
						if (nrm_p[L-1].neg[i]) begin
							nv = -nv;
						end
						nsat       = sat_fn(nv);
						res_c.r[i] = nsat.val;
						nflag      = nflag | nsat.ovf;
					end
					res_c.status = nflag ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
				end
			end
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sl <= res_c;
		end
	end

	// ---------------- valid bits and output skid ----------------
	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	logic take;

	assign en        = !skid_v_q;
	assign req.ready = en;
	assign take      = out_v_q & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p <= '0;
		end else if (en) begin
			v_p <= {v_p[L-1:1], req.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || take) begin
			out_v_q <= v_p[L];
		end else if (v_p[L]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || take) begin
			out_q <= res_sl;
		end else begin
			skid_q <= res_sl;
		end
	end

	assign rsp.valid  = out_v_q;
	assign rsp.r_w    = out_q.r[0];
	assign rsp.r_x    = out_q.r[1];
	assign rsp.r_y    = out_q.r[2];
	assign rsp.r_z    = out_q.r[3];
	assign rsp.status = out_q.status;

	// ---------------- assertions ----------------
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a response while the output register is empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready && !skid_v_q && v_p[L] |=> skid_v_q)
		else $error("stalled final-stage response not captured in skid");

	a_frozen_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_p))
		else $error("pipeline valid bits moved while frozen");

	a_zero_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.status == qau_pkg::ST_ZERO |-> out_q.r == '0)
		else $error("zero-magnitude response carries nonzero components");

endmodule

`default_nettype wire
